// ----- src/stanley_steering_speed_law_defines.svh -----
`ifndef STANLEY_STEERING_SPEED_LAW_DEFINES_SVH
`define STANLEY_STEERING_SPEED_LAW_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define STN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/stn_pkg.sv -----
package stn_pkg;

    localparam int unsigned TabLen = 24;

    localparam logic [2:0] REG_WHEEL_BASE = 3'd0;
    localparam logic [2:0] REG_CT_GAIN    = 3'd1;
    localparam logic [2:0] REG_SOFT_SPEED = 3'd2;
    localparam logic [2:0] REG_THR_GAIN   = 3'd3;
    localparam logic [2:0] REG_BRK_GAIN   = 3'd4;
    localparam logic [2:0] REG_MAX_STEER  = 3'd5;
    localparam logic [2:0] REG_MIN_TARGET = 3'd6;

    localparam logic [15:0] RST_WHEEL_BASE = 16'd640;
    localparam logic [15:0] RST_CT_GAIN    = 16'd307;
    localparam logic [15:0] RST_SOFT_SPEED = 16'd51;
    localparam logic [15:0] RST_THR_GAIN   = 16'd128;
    localparam logic [15:0] RST_BRK_GAIN   = 16'd102;
    localparam logic [13:0] RST_MAX_STEER  = 14'd4915;
    localparam logic [15:0] RST_MIN_TARGET = 16'd256;

    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
    localparam logic [30:0] PI_Q29     = 31'd1686629713;
    localparam logic [28:0] INV_PI_Q30 = 29'd341782638;

    typedef struct packed {
        logic               valid;
        logic               pv;
        logic signed [15:0] he;
        logic signed [15:0] v;
        logic        [14:0] tgt;
        logic signed [16:0] err;
        logic signed [33:0] accel;
        logic        [15:0] thr;
        logic        [48:0] bprod;
        logic        [15:0] brk;
    } t_side;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [33:0] z;
        logic               sp;
        logic               spneg;
    } t_vec;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_rot;

    typedef struct packed {
        logic [62:0] rem;
        logic [48:0] d2;
        logic [17:0] q;
        logic        dz;
        logic        nz;
        logic        nn;
        logic        neg;
    } t_div;

    function automatic logic [31:0] f_atan(input int unsigned idx);
        logic [31:0] a;
        case (idx)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051D;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2F9;
            15: a = 32'h0000517C;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A2F;
            19: a = 32'h00000517;
            20: a = 32'h0000028B;
            21: a = 32'h00000145;
            22: a = 32'h000000A2;
            23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

// ----- src/stanley_steering_speed_law.sv -----
// Stanley steering and speed law. Fully pipelined: one item may start in every
// cycle and busy never rises. Each result appears with o_valid for one
// cycle, once its start transfer has passed through one input stage, a
// row of CORDIC_ITERATIONS atan2 cells, four angle conversion stages, a row of
// CORDIC_ITERATIONS rotation cells, a multiply stage, a divide setup stage,
// eighteen restoring divide cells and the output register. The receiver cannot
// stall, so every result must be taken in its strobe cycle. Configuration writes
// are always ready and should be made only with no item in flight.
`include "stanley_steering_speed_law_defines.svh"
module stanley_steering_speed_law import stn_pkg::*; #(
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_path_valid,
    input  logic signed [15:0] i_heading_error,
    input  logic signed [15:0] i_lateral_error,
    input  logic signed [15:0] i_vehicle_speed,
    input  logic signed [15:0] i_reference_speed,
    output logic               o_valid,
    output logic               o_command_valid,
    output logic signed [14:0] o_steer_angle,
    output logic signed [15:0] o_steer_rate,
    output logic        [15:0] o_throttle,
    output logic        [15:0] o_brake,
    output logic        [14:0] o_target_speed,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data
);
    localparam int unsigned N = CORDIC_ITERATIONS;
    localparam int unsigned QB = 18;

    logic [15:0] r_wb, r_ctg, r_soft, r_thg, r_bg, r_mint;
    logic [13:0] r_maxa;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb   <= RST_WHEEL_BASE;
            r_ctg  <= RST_CT_GAIN;
            r_soft <= RST_SOFT_SPEED;
            r_thg  <= RST_THR_GAIN;
            r_bg   <= RST_BRK_GAIN;
            r_maxa <= RST_MAX_STEER;
            r_mint <= RST_MIN_TARGET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WHEEL_BASE: r_wb   <= i_cfg_data;
                REG_CT_GAIN:    r_ctg  <= i_cfg_data;
                REG_SOFT_SPEED: r_soft <= i_cfg_data;
                REG_THR_GAIN:   r_thg  <= i_cfg_data;
                REG_BRK_GAIN:   r_bg   <= i_cfg_data;
                REG_MAX_STEER:  r_maxa <= i_cfg_data[13:0];
                REG_MIN_TARGET: r_mint <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    t_side n_sd0, r_sd0;
    t_vec  n_v0, r_v0;
    logic signed [32:0] prod_y;
    logic signed [17:0] xs;
    logic signed [35:0] x0, y0;
    logic signed [16:0] ref17, mint17, t17;
    logic        [14:0] tgt;

    always_comb begin
        prod_y = $signed({1'b0, r_ctg}) * i_lateral_error;
        xs     = 18'(i_vehicle_speed) + $signed({2'b00, r_soft});
        x0     = {{10{xs[17]}}, xs, 8'b0};
        y0     = 36'(prod_y);
        n_v0.x = x0;
        n_v0.y = y0;
        n_v0.z = '0;
        n_v0.sp    = (y0 == 0);
        n_v0.spneg = (x0 < 0);
        if (x0 < 0) begin
            if (y0 >= 0) begin
                n_v0.x = y0;
                n_v0.y = -x0;
                n_v0.z = QUARTER_TURN;
            end else begin
                n_v0.x = -y0;
                n_v0.y = x0;
                n_v0.z = -QUARTER_TURN;
            end
        end
        ref17  = 17'(i_reference_speed);
        mint17 = $signed({1'b0, r_mint});
        t17    = (ref17 > mint17) ? ref17 : mint17;
        tgt    = (t17 > 17'sd32767) ? 15'd32767 : t17[14:0];
        n_sd0       = '0;
        n_sd0.valid = start && !busy;
        n_sd0.pv    = i_path_valid;
        n_sd0.he    = i_heading_error;
        n_sd0.v     = i_vehicle_speed;
        n_sd0.tgt   = tgt;
        n_sd0.err   = $signed({2'b00, tgt}) - 17'(i_vehicle_speed);
    end

    always_ff @(posedge i_clk) begin
        r_v0  <= n_v0;
        r_sd0 <= n_sd0;
        if (!i_rst_n) begin
            r_sd0.valid <= 1'b0;
        end
    end

    // atan2 cells
    t_side w_vsd [0:N];
    t_vec  w_vec [0:N];
    assign w_vsd[0] = r_sd0;
    assign w_vec[0] = r_v0;

    for (genvar g = 0; g < N; g++) begin : g_vec
        stn_vec_cell #(.I(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_side (w_vsd[g]),
            .i_data (w_vec[g]),
            .o_side (w_vsd[g+1]),
            .o_data (w_vec[g+1])
        );
    end

    // angle to Q3.13: product; throttle gain product
    t_side n_sda, r_sda;
    logic signed [33:0] zf, zmag;
    logic [62:0] n_p1, r_p1;
    logic n_n1, r_n1;

    always_comb begin
        zf   = w_vec[N].sp ? (w_vec[N].spneg ? HALF_TURN : 34'sd0) : w_vec[N].z;
        zmag = (zf < 0) ? -zf : zf;
        n_p1 = 63'(zmag[31:0]) * 63'(PI_Q29);
        n_n1 = zf < 0;
        n_sda       = w_vsd[N];
        n_sda.accel = $signed({1'b0, r_thg}) * w_vsd[N].err;
    end

    always_ff @(posedge i_clk) begin
        r_p1  <= n_p1;
        r_n1  <= n_n1;
        r_sda <= n_sda;
        if (!i_rst_n) begin
            r_sda.valid <= 1'b0;
        end
    end

    // round, add heading error, clamp; saturate throttle, brake gain product
    t_side n_sdb, r_sdb;
    logic [62:0] p1r;
    logic signed [17:0] ct, st18, maxa18;
    logic signed [14:0] n_steer, r_steer;
    logic [32:0] amag;

    always_comb begin
        p1r    = r_p1 + (63'd1 << 46);
        ct     = r_n1 ? -$signed({2'b00, p1r[62:47]}) : $signed({2'b00, p1r[62:47]});
        st18   = 18'(r_sda.he) + ct;
        maxa18 = $signed({4'b0, r_maxa});
        if (st18 > maxa18) begin
            st18 = maxa18;
        end
        if (st18 < -maxa18) begin
            st18 = -maxa18;
        end
        n_steer = st18[14:0];
        amag    = r_sda.accel[33] ? 33'(-r_sda.accel) : 33'd0;
        n_sdb       = r_sda;
        n_sdb.thr   = (r_sda.accel > 34'sd65535) ? 16'hFFFF :
                      (r_sda.accel[33] ? 16'd0 : r_sda.accel[15:0]);
        n_sdb.bprod = 49'(amag) * 49'(r_bg);
    end

    always_ff @(posedge i_clk) begin
        r_steer <= n_steer;
        r_sdb   <= n_sdb;
        if (!i_rst_n) begin
            r_sdb.valid <= 1'b0;
        end
    end

    // Q3.13 to binary angle: product; round and saturate brake
    t_side n_sdc, r_sdc;
    logic signed [14:0] smag;
    logic [42:0] n_p2, r_p2;
    logic n_n2, r_n2;
    logic signed [14:0] r_steer_c;
    logic [49:0] bsum;

    always_comb begin
        smag = (r_steer < 0) ? -r_steer : r_steer;
        n_p2 = 43'(smag[13:0]) * 43'(INV_PI_Q30);
        n_n2 = r_steer < 0;
        bsum = 50'(r_sdb.bprod) + 50'd128;
        n_sdc     = r_sdb;
        n_sdc.brk = (bsum[49:8] > 42'd65535) ? 16'hFFFF : bsum[23:8];
    end

    always_ff @(posedge i_clk) begin
        r_p2      <= n_p2;
        r_n2      <= n_n2;
        r_steer_c <= r_steer;
        r_sdc     <= n_sdc;
        if (!i_rst_n) begin
            r_sdc.valid <= 1'b0;
        end
    end

    // round and fold into a quarter turn
    t_side r_sdd;
    t_rot  n_r0, r_r0;
    logic [42:0] p2r;
    logic signed [33:0] ba;
    logic signed [14:0] r_steer_d;

    always_comb begin
        p2r = r_p2 + 43'd2048;
        ba  = r_n2 ? -$signed({3'b000, p2r[42:12]}) : $signed({3'b000, p2r[42:12]});
        if (ba > QUARTER_TURN) begin
            ba = ba - HALF_TURN;
        end
        if (ba < -QUARTER_TURN) begin
            ba = ba + HALF_TURN;
        end
        n_r0.x = QUARTER_TURN;
        n_r0.y = '0;
        n_r0.z = ba;
    end

    always_ff @(posedge i_clk) begin
        r_r0      <= n_r0;
        r_steer_d <= r_steer_c;
        r_sdd     <= r_sdc;
        if (!i_rst_n) begin
            r_sdd.valid <= 1'b0;
        end
    end

    // rotation cells
    t_side w_rsd [0:N];
    t_rot  w_rot [0:N];
    logic signed [14:0] r_steer_pipe [0:N];
    assign w_rsd[0] = r_sdd;
    assign w_rot[0] = r_r0;
    assign r_steer_pipe[0] = r_steer_d;

    for (genvar g = 0; g < N; g++) begin : g_rot
        stn_rot_cell #(.I(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_side (w_rsd[g]),
            .i_data (w_rot[g]),
            .o_side (w_rsd[g+1]),
            .o_data (w_rot[g+1])
        );
        always_ff @(posedge i_clk) begin
            r_steer_pipe[g+1] <= r_steer_pipe[g];
        end
    end

    // products for steer rate
    t_side r_sde;
    logic [15:0] wbv;
    logic signed [49:0] r_prs;
    logic signed [50:0] r_prc;
    logic signed [14:0] r_steer_e;

    assign wbv = (r_wb == 16'd0) ? 16'd1 : r_wb;

    always_ff @(posedge i_clk) begin
        r_prs     <= w_rsd[N].v * w_rot[N].y;
        r_prc     <= $signed({1'b0, wbv}) * w_rot[N].x;
        r_steer_e <= r_steer_pipe[N];
        r_sde     <= w_rsd[N];
        if (!i_rst_n) begin
            r_sde.valid <= 1'b0;
        end
    end

    // divide setup
    t_side r_sdf;
    t_div  n_d0, r_d0;
    logic signed [49:0] mn;
    logic signed [50:0] md;
    logic signed [14:0] r_steer_f;

    always_comb begin
        mn = (r_prs < 0) ? -r_prs : r_prs;
        md = (r_prc < 0) ? -r_prc : r_prc;
        n_d0.rem = (63'(mn[46:0]) << 14) + 63'(md[47:0]);
        n_d0.d2  = {md[47:0], 1'b0};
        n_d0.q   = '0;
        n_d0.dz  = (r_prc == 0);
        n_d0.nz  = (r_prs == 0);
        n_d0.nn  = (r_prs < 0);
        n_d0.neg = (r_prs < 0) != (r_prc < 0);
    end

    always_ff @(posedge i_clk) begin
        r_d0      <= n_d0;
        r_steer_f <= r_steer_e;
        r_sdf     <= r_sde;
        if (!i_rst_n) begin
            r_sdf.valid <= 1'b0;
        end
    end

    // divide cells, top quotient bit first
    t_side w_dsd [0:QB];
    t_div  w_div [0:QB];
    logic signed [14:0] r_steer_q [0:QB];
    assign w_dsd[0] = r_sdf;
    assign w_div[0] = r_d0;
    assign r_steer_q[0] = r_steer_f;

    for (genvar g = 0; g < QB; g++) begin : g_div
        stn_div_cell #(.K(QB - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_side (w_dsd[g]),
            .i_data (w_div[g]),
            .o_side (w_dsd[g+1]),
            .o_data (w_div[g+1])
        );
        always_ff @(posedge i_clk) begin
            r_steer_q[g+1] <= r_steer_q[g];
        end
    end

    // saturate and drive results
    t_side sdo;
    t_div  dvo;
    logic signed [15:0] rate;
    logic r_valid;
    logic r_cmd;
    logic signed [14:0] r_steer_o;
    logic signed [15:0] r_rate;
    logic [15:0] r_thr, r_brk;
    logic [14:0] r_tgt;

    assign sdo = w_dsd[QB];
    assign dvo = w_div[QB];

    always_comb begin
        if (dvo.dz) begin
            rate = dvo.nz ? 16'sd0 : (dvo.nn ? -16'sd32768 : 16'sd32767);
        end else if (dvo.q[QB-1]) begin
            rate = dvo.neg ? -16'sd32768 : 16'sd32767;
        end else if (dvo.neg) begin
            rate = (dvo.q > 18'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, dvo.q}));
        end else begin
            rate = (dvo.q > 18'd32767) ? 16'sd32767 : $signed(dvo.q[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_valid   <= sdo.valid;
        r_cmd     <= sdo.pv;
        r_steer_o <= sdo.pv ? r_steer_q[QB] : 15'sd0;
        r_rate    <= sdo.pv ? rate : 16'sd0;
        r_thr     <= sdo.pv ? sdo.thr : 16'd0;
        r_brk     <= sdo.pv ? sdo.brk : 16'd0;
        r_tgt     <= sdo.pv ? sdo.tgt : 15'd0;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid         = r_valid;
    assign o_command_valid = r_cmd;
    assign o_steer_angle   = r_steer_o;
    assign o_steer_rate    = r_rate;
    assign o_throttle      = r_thr;
    assign o_brake         = r_brk;
    assign o_target_speed  = r_tgt;

    `STN_ASSERT_NOW(a_no_thr_and_brk, o_valid, (o_throttle == 16'd0) || (o_brake == 16'd0), "throttle and brake both set")
    `STN_ASSERT_NOW(a_invalid_zero, o_valid && !o_command_valid, (o_steer_angle == 15'sd0) && (o_steer_rate == 16'sd0) && (o_target_speed == 15'd0), "invalid path gave nonzero command")
    `STN_ASSERT_NOW(a_tgt_floor, o_command_valid && o_valid, o_target_speed[14] == 1'b0 || o_target_speed != 15'd0, "target speed out of range")
    `STN_ASSERT_NEXT(a_cfg_hold, !i_cfg_valid && $stable(r_maxa), $stable(r_maxa), "steer clamp changed without transfer")
endmodule

// ----- src/stn_vec_cell.sv -----
module stn_vec_cell import stn_pkg::*; #(
    parameter int unsigned I = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_side i_side,
    input  t_vec  i_data,
    output t_side o_side,
    output t_vec  o_data
);
    localparam logic signed [33:0] ANG = $signed({2'b00, f_atan(I)});

    t_side r_side;
    t_vec  r_data;
    t_vec  n_data;
    logic signed [35:0] dx;
    logic signed [35:0] dy;

    always_comb begin
        dx = i_data.y >>> I;
        dy = i_data.x >>> I;
        n_data = i_data;
        if (i_data.y >= 0) begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ANG;
        end else begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_side <= i_side;
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end
    end

    assign o_side = r_side;
    assign o_data = r_data;
endmodule

// ----- src/stn_rot_cell.sv -----
module stn_rot_cell import stn_pkg::*; #(
    parameter int unsigned I = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_side i_side,
    input  t_rot  i_data,
    output t_side o_side,
    output t_rot  o_data
);
    localparam logic signed [33:0] ANG = $signed({2'b00, f_atan(I)});

    t_side r_side;
    t_rot  r_data;
    t_rot  n_data;
    logic signed [33:0] dx;
    logic signed [33:0] dy;

    always_comb begin
        dx = i_data.y >>> I;
        dy = i_data.x >>> I;
        if (i_data.z >= 0) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ANG;
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_side <= i_side;
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end
    end

    assign o_side = r_side;
    assign o_data = r_data;
endmodule

// ----- src/stn_div_cell.sv -----
module stn_div_cell import stn_pkg::*; #(
    parameter int unsigned K = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_side i_side,
    input  t_div  i_data,
    output t_side o_side,
    output t_div  o_data
);
    t_side r_side;
    t_div  r_data;
    t_div  n_data;
    logic [66:0] dsh;
    logic [66:0] remx;
    logic [66:0] diff;

    always_comb begin
        dsh  = {18'b0, i_data.d2} << K;
        remx = {4'b0, i_data.rem};
        diff = remx - dsh;
        n_data = i_data;
        if (remx >= dsh) begin
            n_data.rem  = diff[62:0];
            n_data.q[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_side <= i_side;
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end
    end

    assign o_side = r_side;
    assign o_data = r_data;
endmodule

// ----- test/stanley_checker.sv -----
module stanley_checker import stn_pkg::*; #(
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_path_valid,
    input  logic signed [15:0] i_heading_error,
    input  logic signed [15:0] i_lateral_error,
    input  logic signed [15:0] i_vehicle_speed,
    input  logic signed [15:0] i_reference_speed,
    input  logic               o_valid,
    input  logic               o_command_valid,
    input  logic signed [14:0] o_steer_angle,
    input  logic signed [15:0] o_steer_rate,
    input  logic        [15:0] o_throttle,
    input  logic        [15:0] o_brake,
    input  logic        [14:0] o_target_speed,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        cmd_valid;
        logic [14:0] steer;
        logic [15:0] rate;
        logic [15:0] thr;
        logic [15:0] brk;
        logic [14:0] tgt;
    } t_command;

    localparam longint BA_HALF    = 64'sd2147483648;
    localparam longint BA_QUARTER = 64'sd1073741824;

    longint arctan_lut [24] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051
    };

    logic [15:0] axle_span, ct_gain, soft_speed, thr_gain, brk_gain, min_target;
    logic [13:0] max_steer;
    t_command    cmd_queue[$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = cmd_queue.size();

    function automatic int unsigned stages();
        return (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (y == 0) return (x >= 0) ? 0 : BA_HALF;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = BA_QUARTER;
            end else begin
                x = -y; y = t; z = -BA_QUARTER;
            end
        end
        for (int i = 0; i < stages(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_lut[i];
            end else begin
                x -= dx; y += dy; z -= arctan_lut[i];
            end
        end
        return z;
    endfunction

    task automatic rotate_unit(input longint z, output longint c, output longint s);
        longint x, y, dx, dy;
        x = BA_QUARTER;
        y = 0;
        for (int i = 0; i < stages(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_lut[i];
            end else begin
                x += dx; y -= dy; z += arctan_lut[i];
            end
        end
        c = x;
        s = y;
    endtask

    function automatic longint binary_to_rad(longint ba);
        longint unsigned m;
        longint r;
        m = (ba < 0) ? -ba : ba;
        r = longint'((m * 64'd1686629713 + (64'd1 << 46)) >> 47);
        return (ba < 0) ? -r : r;
    endfunction

    function automatic longint rad_to_binary(longint a);
        longint unsigned m;
        longint r;
        m = (a < 0) ? -a : a;
        r = longint'((m * 64'd341782638 + 64'd2048) >> 12);
        return (a < 0) ? -r : r;
    endfunction

    function automatic longint rate_divide(longint num, longint den);
        longint unsigned mn, md, q;
        logic neg;
        if (den == 0) begin
            if (num == 0) return 0;
            return (num > 0) ? 32767 : -32768;
        end
        neg = (num < 0) != (den < 0);
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q = (2 * mn + md) / (2 * md);
        if (neg) return (q > 32768) ? -32768 : -longint'(q);
        return (q > 32767) ? 32767 : longint'(q);
    endfunction

    task automatic predict_command(output t_command cmd);
        longint he, lat, v, refv, y, x, steer, maxa, ba, c, s, wb, rate;
        longint tgt, err, accel;
        longint unsigned thr, brk;
        cmd = '0;
        if (!i_path_valid) return;
        he   = i_heading_error;
        lat  = i_lateral_error;
        v    = i_vehicle_speed;
        refv = i_reference_speed;
        y = longint'(ct_gain) * lat;
        x = (v + longint'(soft_speed)) * 256;
        steer = he + binary_to_rad(vector_angle(y, x));
        maxa = max_steer;
        if (steer > maxa) steer = maxa;
        if (steer < -maxa) steer = -maxa;
        ba = rad_to_binary(steer);
        if (ba > BA_QUARTER) ba -= BA_HALF;
        if (ba < -BA_QUARTER) ba += BA_HALF;
        rotate_unit(ba, c, s);
        wb = (axle_span == 0) ? 1 : longint'(axle_span);
        rate = rate_divide(v * s * 8192, wb * c);
        tgt = (refv > longint'(min_target)) ? refv : longint'(min_target);
        if (tgt > 32767) tgt = 32767;
        err = tgt - v;
        accel = longint'(thr_gain) * err;
        thr = 0;
        brk = 0;
        if (accel >= 0) begin
            thr = (accel > 65535) ? 65535 : accel;
        end else begin
            brk = (longint'(-accel) * brk_gain + 128) >> 8;
            if (brk > 65535) brk = 65535;
        end
        cmd.cmd_valid = 1'b1;
        cmd.steer     = steer[14:0];
        cmd.rate      = rate[15:0];
        cmd.thr       = thr[15:0];
        cmd.brk       = brk[15:0];
        cmd.tgt       = tgt[14:0];
    endtask

    task automatic report(input string field, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d, want %0d", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_command cmd;
        if (!i_rst_n) begin
            axle_span  <= RST_WHEEL_BASE;
            ct_gain    <= RST_CT_GAIN;
            soft_speed <= RST_SOFT_SPEED;
            thr_gain   <= RST_THR_GAIN;
            brk_gain   <= RST_BRK_GAIN;
            max_steer  <= RST_MAX_STEER;
            min_target <= RST_MIN_TARGET;
            cmd_queue.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_WHEEL_BASE: axle_span  <= i_cfg_data;
                    REG_CT_GAIN:    ct_gain    <= i_cfg_data;
                    REG_SOFT_SPEED: soft_speed <= i_cfg_data;
                    REG_THR_GAIN:   thr_gain   <= i_cfg_data;
                    REG_BRK_GAIN:   brk_gain   <= i_cfg_data;
                    REG_MAX_STEER:  max_steer  <= i_cfg_data[13:0];
                    REG_MIN_TARGET: min_target <= i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                predict_command(cmd);
                cmd_queue.push_back(cmd);
            end
            if (o_valid) begin
                if (cmd_queue.size() == 0) begin
                    $display("%0t: command transfer with nothing pending", $time);
                    fail_count++;
                end else begin
                    cmd = cmd_queue.pop_front();
                    if (o_command_valid !== cmd.cmd_valid)
                        report("command_valid", o_command_valid, cmd.cmd_valid);
                    if (o_steer_angle !== cmd.steer)
                        report("steer_angle", o_steer_angle, $signed(cmd.steer));
                    if (o_steer_rate !== cmd.rate)
                        report("steer_rate", o_steer_rate, $signed(cmd.rate));
                    if (o_throttle !== cmd.thr)
                        report("throttle", o_throttle, cmd.thr);
                    if (o_brake !== cmd.brk)
                        report("brake", o_brake, cmd.brk);
                    if (o_target_speed !== cmd.tgt)
                        report("target_speed", o_target_speed, cmd.tgt);
                end
            end
        end
    end
endmodule

// ----- test/tb.sv -----
module tb import stn_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 2 * 16 + 26;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_path_valid = 1'b0;
    logic signed [15:0] i_heading_error = '0;
    logic signed [15:0] i_lateral_error = '0;
    logic signed [15:0] i_vehicle_speed = '0;
    logic signed [15:0] i_reference_speed = '0;
    logic               o_valid;
    logic               o_command_valid;
    logic signed [14:0] o_steer_angle;
    logic signed [15:0] o_steer_rate;
    logic        [15:0] o_throttle;
    logic        [15:0] o_brake;
    logic        [14:0] o_target_speed;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic        [2:0]  i_cfg_index = '0;
    logic        [15:0] i_cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 gap_pct;

    always #5 i_clk = ~i_clk;

    stanley_steering_speed_law DUT (.*);

    stanley_checker u_checker (.*, .o_fail_count(fail_count), .o_pending(pending));

    task automatic send_item(input logic pv, input logic [15:0] he, input logic [15:0] lat,
                             input logic [15:0] v, input logic [15:0] rs);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_path_valid      <= pv;
        i_heading_error   <= he;
        i_lateral_error   <= lat;
        i_vehicle_speed   <= v;
        i_reference_speed <= rs;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(3))
            0:       return 16'($signed($urandom_range(1024)) - 512);
            1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_setting(input int k);
        case (k)
            1: begin
                for (int r = 0; r < 7; r++) write_reg(3'(r), 16'hFFFF);
            end
            2: begin
                for (int r = 0; r < 7; r++) write_reg(3'(r), 16'h0000);
            end
            default: begin
                write_reg(REG_WHEEL_BASE, 16'($urandom_range(1, 2048)));
                write_reg(REG_CT_GAIN,    16'($urandom_range(0, 1024)));
                write_reg(REG_SOFT_SPEED, 16'($urandom_range(0, 512)));
                write_reg(REG_THR_GAIN,   16'($urandom_range(0, 1024)));
                write_reg(REG_BRK_GAIN,   16'($urandom_range(0, 1024)));
                write_reg(REG_MAX_STEER,  16'($urandom_range(0, 12868)));
                write_reg(REG_MIN_TARGET, 16'($urandom_range(0, 2048)));
                write_reg(REG_UNUSED, 16'($urandom));
            end
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        gap_pct = 9;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(1'b0, 16'h1234, 16'h5678, 16'h0100, 16'h0200);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h0200, 16'h0100);
        send_item(1'b1, 16'h0000, 16'h0000, 16'hFC00, 16'h0100);
        send_item(1'b1, 16'h0000, 16'h0100, 16'hFFCD, 16'h0000);
        send_item(1'b1, 16'h6488, 16'h0000, 16'h0100, 16'h0100);
        send_item(1'b1, 16'h9B78, 16'h0000, 16'h0100, 16'h0100);
        send_item(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(1'b1, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000);
        send_item(1'b1, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
        send_item(1'b1, 16'h0400, 16'h0080, 16'h0500, 16'h0600);
        send_item(1'b1, 16'hFC00, 16'hFF80, 16'h0500, 16'h0300);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(1'b1, 16'h1000, 16'h0040, 16'h0000, 16'h0100);
        drain();

        for (int k = 0; k < 6; k++) begin
            gap_pct = (k < 2) ? 9 : (k < 4) ? 46 : 0;
            if (k > 0) load_setting(k);
            for (int n = 0; n < 285; n++) begin
                send_item($urandom_range(9) != 0, rand_value(), rand_value(),
                          rand_value(), rand_value());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
